### hw/rtl/jit_pkg.sv
// Package for the job number table: port widths, command and status codes,
// and the sequencer state type.
// No dependencies; job_id_table and jit_chk refer to it by scoped names.
package jit_pkg;

  // Fixed widths of the fields on the ports.
  localparam int CMD_W = 3;
  localparam int PID_W = 22;
  localparam int NUM_W = 16;
  localparam int ST_W  = 2;
  localparam int ENT_W = 5;

  // Operation codes; the two codes above list mean nothing.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_FIND_NUM = 3'd2,
    CMD_FIND_PID = 3'd3,
    CMD_MARK     = 3'd4,
    CMD_LIST     = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NONE    = 2'd2,
    ST_EXHAUST = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_OUT,
    S_RESP
  } state_t;

endpackage

### hw/rtl/jit_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used by the job number table for its entry store.
module jit_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data word holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/job_id_table.sv
// Job number table: an insertion-ordered table of job numbers, process ids
// and run marks, kept in one RAM and walked by a small sequencer.
// Depends on jit_pkg and jit_ram.
//
// Usage
// - Input channel (in_valid/in_ready) carries one command word: add, remove
//   by pid, find by number, find by pid, mark stopped by pid, or list.
// - Result channel (out_valid/out_ready) returns one word per command, or for
//   a non-empty list one word per entry, oldest first; out_last marks the final word.
// - A command walks the table through the RAM's single read port,
//   one entry per cycle; a search stops at its hit.
//   Remove then moves each later entry down at one per cycle.
//   A list delivers one word per cycle while the receiver takes them.
// - One command is in work at a time; in_ready is high only while idle. A
//   finished result can wait in the output register while the next command
//   is accepted.
// - When the receiver stalls, the output word holds and the sequencer waits.
// - Reset empties the table (the entry count goes to zero); the RAM itself
//   is not cleared, since entries at or above the count are never read.
module job_id_table #(
  parameter int SLOTS    = 16,
  parameter int NUM_BITS = 16,
  parameter int PID_BITS = 22
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Command channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [jit_pkg::CMD_W-1:0]   in_cmd,
  input  logic [jit_pkg::PID_W-1:0]   in_proc_id,
  input  logic [jit_pkg::NUM_W-1:0]   in_query_num,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jit_pkg::ST_W-1:0]    out_status,
  output logic [jit_pkg::NUM_W-1:0]   out_job_num,
  output logic [jit_pkg::PID_W-1:0]   out_out_pid,
  output logic                        out_stopped,
  output logic [jit_pkg::ENT_W-1:0]   out_entries,
  output logic                        out_last
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = 1 + PID_BITS + NUM_BITS;

  typedef struct packed {
    logic                stp;
    logic [PID_BITS-1:0] pid;
    logic [NUM_BITS-1:0] num;
  } entry_t;

  // Control state.
  jit_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             dv_r, dv_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Command and working registers.
  jit_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic [NUM_BITS-1:0] qnum_r, qnum_nxt;
  logic [AW-1:0]    didx_r, didx_nxt;
  logic [NUM_BITS-1:0] top_r, top_nxt;
  jit_pkg::status_t res_status_r, res_status_nxt;
  entry_t           res_ent_r, res_ent_nxt;

  // Output word.
  jit_pkg::status_t out_status_r, out_status_nxt;
  entry_t           out_ent_r, out_ent_nxt;
  logic [CW-1:0]    out_fill_r, out_fill_nxt;
  logic             out_last_r, out_last_nxt;

  // RAM ports.
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  entry_t           rdata, wr_data;

  // Derived conditions.
  jit_pkg::cmd_t    cmd_in;
  logic [PID_BITS-1:0] pid_in;
  logic [NUM_BITS-1:0] qnum_in;
  logic [CW-1:0]    rd_idx_inc;
  logic             accept, hit, scan_hit, scan_more, scan_end, out_free, list_last;
  logic             full;

  jit_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  // Input word, resized to the stored widths.
  assign cmd_in  = jit_pkg::cmd_t'(in_cmd);
  assign pid_in  = PID_BITS'(in_proc_id);
  assign qnum_in = NUM_BITS'(in_query_num);
  assign in_ready = (state_r == jit_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  // Scan bookkeeping: a read issued last cycle delivers its word this cycle.
  assign full       = (fill_r == CW'(SLOTS));
  assign rd_idx_inc = rd_idx_r + CW'(1);
  assign scan_more  = (rd_idx_r < fill_r);
  assign scan_end   = !dv_r && !scan_more;
  assign out_free   = !out_valid_r || out_ready;
  assign list_last  = (rd_idx_inc == fill_r);

  // Key compare on the word just read.
  always_comb begin
    case (cmd_r)
      jit_pkg::CMD_FIND_NUM: hit = (rdata.num == qnum_r);
      default:               hit = (rdata.pid == pid_r);
    endcase
  end
  assign scan_hit = dv_r && hit && (cmd_r != jit_pkg::CMD_ADD);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jit_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            jit_pkg::CMD_ADD:  state_nxt = full ? jit_pkg::S_RESP : jit_pkg::S_SCAN;
            jit_pkg::CMD_LIST: begin
              state_nxt = (fill_r == '0) ? jit_pkg::S_RESP : jit_pkg::S_LIST_RD;
            end
            default: begin
              if (cmd_in inside {jit_pkg::CMD_REMOVE, jit_pkg::CMD_FIND_NUM,
                                 jit_pkg::CMD_FIND_PID, jit_pkg::CMD_MARK}) begin
                state_nxt = jit_pkg::S_SCAN;
              end else begin
                state_nxt = jit_pkg::S_RESP;
              end
            end
          endcase
        end
      end
      jit_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_nxt = (cmd_r == jit_pkg::CMD_REMOVE) ? jit_pkg::S_SHIFT : jit_pkg::S_RESP;
        end else if (scan_end) begin
          state_nxt = jit_pkg::S_RESP;
        end
      end
      jit_pkg::S_SHIFT: begin
        if (scan_end) begin
          state_nxt = jit_pkg::S_RESP;
        end
      end
      jit_pkg::S_LIST_RD: state_nxt = jit_pkg::S_LIST_OUT;
      jit_pkg::S_LIST_OUT: begin
        if (out_free && list_last) begin
          state_nxt = jit_pkg::S_IDLE;
        end
      end
      jit_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = jit_pkg::S_IDLE;
        end
      end
      default: state_nxt = jit_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM accesses and the output word.
  always_comb begin
    fill_nxt       = fill_r;
    rd_idx_nxt     = rd_idx_r;
    dv_nxt         = 1'b0;
    didx_nxt       = didx_r;
    cmd_nxt        = cmd_r;
    pid_nxt        = pid_r;
    qnum_nxt       = qnum_r;
    top_nxt        = top_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_fill_nxt   = out_fill_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = didx_r;
    wr_data        = rdata;

    case (state_r)
      // Capture the command and prepare the walk from the oldest entry.
      jit_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt        = cmd_in;
          pid_nxt        = pid_in;
          qnum_nxt       = qnum_in;
          rd_idx_nxt     = '0;
          top_nxt        = '0;
          res_ent_nxt    = '0;
          res_status_nxt = jit_pkg::ST_NONE;
          if (cmd_in == jit_pkg::CMD_ADD && full) begin
            res_status_nxt = jit_pkg::ST_FULL;
          end
        end
      end

      // Walk the table, one read per cycle; a hit stops further reads so no
      // write-back can meet a read of the same entry.
      jit_pkg::S_SCAN: begin
        if (dv_r && cmd_r == jit_pkg::CMD_ADD && rdata.num > top_r) begin
          top_nxt = rdata.num;
        end
        if (!scan_hit && scan_more) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_inc;
          dv_nxt     = 1'b1;
          didx_nxt   = rd_idx_r[AW-1:0];
        end
        if (scan_hit) begin
          res_status_nxt = jit_pkg::ST_OK;
          res_ent_nxt    = rdata;
          if (cmd_r == jit_pkg::CMD_MARK) begin
            wr_en           = 1'b1;
            wr_data.stp     = 1'b1;
            res_ent_nxt.stp = 1'b1;
          end
          if (cmd_r == jit_pkg::CMD_REMOVE) begin
            rd_idx_nxt = CW'(didx_r) + CW'(1);
          end
        end else if (scan_end && cmd_r == jit_pkg::CMD_ADD) begin
          if (top_r == '1) begin
            res_status_nxt = jit_pkg::ST_EXHAUST;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = fill_r[AW-1:0];
            wr_data.stp     = 1'b0;
            wr_data.pid     = pid_r;
            wr_data.num     = top_r + NUM_BITS'(1);
            fill_nxt        = fill_r + CW'(1);
            res_status_nxt  = jit_pkg::ST_OK;
            res_ent_nxt.stp = 1'b0;
            res_ent_nxt.pid = pid_r;
            res_ent_nxt.num = top_r + NUM_BITS'(1);
          end
        end
      end

      // Close the gap left by a removed entry: read entry i, write it to i-1.
      jit_pkg::S_SHIFT: begin
        if (scan_more) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_inc;
          dv_nxt     = 1'b1;
          didx_nxt   = rd_idx_r[AW-1:0];
        end
        if (dv_r) begin
          wr_en   = 1'b1;
          wr_addr = didx_r - AW'(1);
        end
        if (scan_end) begin
          fill_nxt = fill_r - CW'(1);
        end
      end

      // First read of a list.
      jit_pkg::S_LIST_RD: begin
        rd_en = 1'b1;
      end

      // Hand out one entry per cycle while the receiver takes them, and fetch the next behind it.
      jit_pkg::S_LIST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = jit_pkg::ST_OK;
          out_ent_nxt    = rdata;
          out_fill_nxt   = fill_r;
          out_last_nxt   = list_last;
          if (!list_last) begin
            rd_en      = 1'b1;
            rd_addr    = rd_idx_inc[AW-1:0];
            rd_idx_nxt = rd_idx_inc;
          end
        end
      end

      // Single result word.
      jit_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ent_nxt    = res_ent_r;
          out_fill_nxt   = fill_r;
          out_last_nxt   = 1'b1;
        end
      end

      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jit_pkg::S_IDLE;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pid_r        <= pid_nxt;
    qnum_r       <= qnum_nxt;
    didx_r       <= didx_nxt;
    top_r        <= top_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_fill_r   <= out_fill_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Result ports.
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_job_num = jit_pkg::NUM_W'(out_ent_r.num);
  assign out_out_pid = jit_pkg::PID_W'(out_ent_r.pid);
  assign out_stopped = out_ent_r.stp;
  assign out_entries = jit_pkg::ENT_W'(out_fill_r);
  assign out_last    = out_last_r;

endmodule

### hw/rtl/jit_chk.sv
// Port-level checks for the job number table, and the bind that attaches
// them to every instance of job_id_table. Depends on jit_pkg.
module jit_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [jit_pkg::ST_W-1:0]  out_status,
  input logic [jit_pkg::NUM_W-1:0] out_job_num,
  input logic [jit_pkg::PID_W-1:0] out_out_pid,
  input logic                      out_stopped,
  input logic [jit_pkg::ENT_W-1:0] out_entries,
  input logic                      out_last
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_job_num)
      && $stable(out_out_pid) && $stable(out_stopped) && $stable(out_entries)
      && $stable(out_last))
    else $error("result word changed while stalled");

  // A failed command gives one closing word with empty entry fields.
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != jit_pkg::ST_OK |-> out_last && out_job_num == '0
      && out_out_pid == '0 && !out_stopped)
    else $error("failed command reported entry fields");

  // One command at a time: the block is busy right after taking a word.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in work");

endmodule

bind job_id_table jit_chk u_jit_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_status  (out_status),
  .out_job_num (out_job_num),
  .out_out_pid (out_out_pid),
  .out_stopped (out_stopped),
  .out_entries (out_entries),
  .out_last    (out_last)
);
